>>> hw/rtl/gathered_block_update_unit_assert.svh
// Assertion macros for the gathered block update unit.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef GATHERED_BLOCK_UPDATE_UNIT_ASSERT_SVH
`define GATHERED_BLOCK_UPDATE_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define GBU_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gbu assertion failed");
`define GBU_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gbu assertion failed");
`else
`define GBU_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define GBU_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> hw/rtl/gbu_pkg.sv
// Package for the gathered block update unit: transaction types, codes, constants.
// Used by gathered_block_update_unit; no dependencies.
package gbu_pkg;

   localparam int DEF_TARGET_DEPTH = 4096;
   localparam int DEF_MAX_COLUMNS  = 64;

   localparam logic [1:0] MODE_LOAD_TARGET = 2'd0;
   localparam logic [1:0] MODE_LOAD_MULT   = 2'd1;
   localparam logic [1:0] MODE_COEF        = 2'd2;
   localparam logic [1:0] MODE_READ        = 2'd3;

   localparam logic KIND_READ = 1'b0;
   localparam logic KIND_ROW  = 1'b1;

   localparam int  CSR_ADDR_W   = 3;
   localparam logic REG_COLUMNS = 1'b0;

   localparam logic [63:0] DBL_DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
   localparam logic [63:0] DBL_QUIET_BIT   = 64'h0008_0000_0000_0000;

   typedef struct packed {
      logic [1:0]  mode;
      logic [11:0] index;
      logic [63:0] value;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [11:0] target_index;
      logic [63:0] result_value;
   } rsp_type;

endpackage

>>> hw/rtl/gbu_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module gbu_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> hw/rtl/gathered_block_update_unit.sv
// Gathered block update unit: target and multiplier stores, row update sequencer.
// Each coefficient runs through a four-pass 27x27 product and two serial normalize and
// round passes; special operands or an exact zero difference skip part of that path.
// One transaction in flight; a held result stalls the unit until it is taken.
// Synchronous active-high reset clears control state; stores undefined until written.
`include "gathered_block_update_unit_assert.svh"

module gathered_block_update_unit import gbu_pkg::*; #(
   parameter int TARGET_DEPTH = DEF_TARGET_DEPTH,
   parameter int MAX_COLUMNS  = DEF_MAX_COLUMNS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam int TAW = (TARGET_DEPTH > 1) ? $clog2(TARGET_DEPTH) : 1;
   localparam int CW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int unsigned RECIP = (32'd1 << 24) / TARGET_DEPTH;

   typedef enum logic [3:0] {
      ST_IDLE, ST_READ, ST_MUL, ST_MPACK, ST_LZC, ST_NORM, ST_DEN, ST_RND,
      ST_ALIGN, ST_ADD, ST_DONE
   } st_type;

   function automatic logic [TAW-1:0] taddr(input logic [11:0] x);
      logic [36:0] p;
      logic [12:0] q;
      logic [36:0] r;
      p = 37'(x) * 37'(RECIP);
      q = p[36:24];
      r = 37'(x) - 37'(q) * 37'(TARGET_DEPTH);
      if (r >= 37'(TARGET_DEPTH)) begin
         r = r - 37'(TARGET_DEPTH);
      end
      if (TARGET_DEPTH >= 4096) begin
         return TAW'(x);
      end else begin
         return TAW'(r);
      end
   endfunction

   function automatic logic [6:0] clz128(input logic [127:0] m);
      logic [6:0] lz;
      lz = 7'd0;
      for (int i = 0; i < 128; i++) begin
         if (m[i]) begin
            lz = 7'(127 - i);
         end
      end
      return lz;
   endfunction

   function automatic logic is_nan(input logic [63:0] d);
      return (d[62:52] == 11'h7FF) && (d[51:0] != 52'd0);
   endfunction

   function automatic logic is_inf(input logic [63:0] d);
      return (d[62:52] == 11'h7FF) && (d[51:0] == 52'd0);
   endfunction

   function automatic logic is_zero(input logic [63:0] d);
      return d[62:0] == 63'd0;
   endfunction

   st_type                state_ff, state_in;
   logic [1:0]            mode_ff, mode_in;
   logic [11:0]           idx_ff, idx_in;
   logic [63:0]           coef_ff, coef_in;
   logic [63:0]           mulv_ff, mulv_in;
   logic                  first_ff, first_in;
   logic [11:0]           row_target_ff, row_target_in;
   logic [6:0]            col_count_ff, col_count_in;
   logic [63:0]           running_ff, running_in;
   logic [63:0]           prod_ff, prod_in;
   logic                  phase_ff, phase_in;
   logic [1:0]            mul_cnt_ff, mul_cnt_in;
   logic [105:0]          macc_ff, macc_in;
   logic                  rp_sign_ff, rp_sign_in;
   logic [127:0]          rp_m_ff, rp_m_in;
   logic signed [13:0]    rp_e_ff, rp_e_in;
   logic [6:0]            lz_ff, lz_in;
   logic signed [13:0]    be_ff, be_in;
   logic [127:0]          big_ff, big_in;
   logic [127:0]          small_ff, small_in;
   logic                  eff_sub_ff, eff_sub_in;
   logic [6:0]            cfg_cols_ff, cfg_cols_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_in;

   logic                  t_we, t_re;
   logic [TAW-1:0]        t_waddr, t_raddr;
   logic [63:0]           t_wdata, t_rdata;
   logic                  m_we, m_re;
   logic [CW-1:0]         m_waddr, m_raddr;
   logic [63:0]           m_rdata;

   logic                  accept, out_free, rsp_load, csr_write;
   logic [10:0]           width11;

   gbu_ram #(.WIDTH(64), .DEPTH(TARGET_DEPTH)) u_target_ram (
      .clock(clock), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
      .re(t_re), .raddr(t_raddr), .rdata(t_rdata)
   );

   gbu_ram #(.WIDTH(64), .DEPTH(MAX_COLUMNS)) u_mult_ram (
      .clock(clock), .we(m_we), .waddr(m_waddr), .wdata(req_data.value),
      .re(m_re), .raddr(m_raddr), .rdata(m_rdata)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign accept     = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr[2] == REG_COLUMNS);
   assign csr_prdata = (csr_paddr[2] == REG_COLUMNS) ? {25'd0, cfg_cols_ff} : 32'd0;

   always_comb begin
      if (cfg_cols_ff == 7'd0) begin
         width11 = 11'd1;
      end else if (11'(cfg_cols_ff) > 11'(MAX_COLUMNS)) begin
         width11 = 11'(MAX_COLUMNS);
      end else begin
         width11 = 11'(cfg_cols_ff);
      end
   end

   always_comb begin
      logic [52:0]  ma, mb, mbig, msml;
      logic [26:0]  pa, pb;
      logic [53:0]  pp;
      logic [6:0]   pp_sh;
      logic [10:0]  ea, eb, ebig, esml, dexp, bexp;
      logic [13:0]  sh_full;
      logic [7:0]   sh;
      logic [52:0]  mant53;
      logic [53:0]  m54;
      logic         rinc;
      logic [51:0]  frac;
      logic [63:0]  res, xv, yv, bigv, smlv;
      logic [127:0] msum;
      logic [6:0]   cnt_next;
      logic signed [13:0] benew;

      state_in      = state_ff;
      mode_in       = mode_ff;
      idx_in        = idx_ff;
      coef_in       = coef_ff;
      mulv_in       = mulv_ff;
      first_in      = first_ff;
      row_target_in = row_target_ff;
      col_count_in  = col_count_ff;
      running_in    = running_ff;
      prod_in       = prod_ff;
      phase_in      = phase_ff;
      mul_cnt_in    = mul_cnt_ff;
      macc_in       = macc_ff;
      rp_sign_in    = rp_sign_ff;
      rp_m_in       = rp_m_ff;
      rp_e_in       = rp_e_ff;
      lz_in         = lz_ff;
      be_in         = be_ff;
      big_in        = big_ff;
      small_in      = small_ff;
      eff_sub_in    = eff_sub_ff;
      cfg_cols_in   = csr_write ? csr_pwdata[6:0] : cfg_cols_ff;
      rsp_load      = 1'b0;
      rsp_in        = rsp_data_ff;
      t_we          = 1'b0;
      t_waddr       = taddr(req_data.index);
      t_wdata       = req_data.value;
      t_re          = 1'b0;
      t_raddr       = taddr(req_data.index);
      m_we          = 1'b0;
      m_waddr       = CW'(req_data.index);
      m_re          = 1'b0;
      m_raddr       = (11'(col_count_ff) >= 11'(MAX_COLUMNS)) ? CW'(MAX_COLUMNS - 1)
                                                                : CW'(col_count_ff);

      ma = {coef_ff[62:52] != 11'd0, coef_ff[51:0]};
      mb = {mulv_ff[62:52] != 11'd0, mulv_ff[51:0]};
      ea = (coef_ff[62:52] == 11'd0) ? 11'd1 : coef_ff[62:52];
      eb = (mulv_ff[62:52] == 11'd0) ? 11'd1 : mulv_ff[62:52];
      pa = mul_cnt_ff[1] ? {1'b0, ma[52:27]} : ma[26:0];
      pb = mul_cnt_ff[0] ? {1'b0, mb[52:27]} : mb[26:0];
      pp = 54'(pa) * 54'(pb);
      case (mul_cnt_ff)
         2'd0:    pp_sh = 7'd0;
         2'd3:    pp_sh = 7'd54;
         default: pp_sh = 7'd27;
      endcase

      sh_full = 14'(14'sd1 - be_ff);
      sh      = (sh_full > 14'd128) ? 8'd128 : sh_full[7:0];

      mant53 = rp_m_ff[127:75];
      rinc   = rp_m_ff[74] && ((|rp_m_ff[73:0]) || mant53[0]);
      m54    = {1'b0, mant53} + 54'(rinc);
      benew  = be_ff;
      frac   = m54[51:0];
      if (be_ff < 14'sd1) begin
         res = {rp_sign_ff, 10'd0, m54[52], m54[51:0]};
      end else begin
         if (m54[53]) begin
            benew = be_ff + 14'sd1;
            frac  = 52'd0;
         end
         if (benew >= 14'sd2047) begin
            res = {rp_sign_ff, 11'h7FF, 52'd0};
         end else begin
            res = {rp_sign_ff, benew[10:0], frac};
         end
      end

      xv   = running_ff;
      yv   = {~prod_ff[63], prod_ff[62:0]};
      bigv = (yv[62:0] > xv[62:0]) ? yv : xv;
      smlv = (yv[62:0] > xv[62:0]) ? xv : yv;
      mbig = {bigv[62:52] != 11'd0, bigv[51:0]};
      msml = {smlv[62:52] != 11'd0, smlv[51:0]};
      ebig = (bigv[62:52] == 11'd0) ? 11'd1 : bigv[62:52];
      esml = (smlv[62:52] == 11'd0) ? 11'd1 : smlv[62:52];
      dexp = ebig - esml;
      bexp = ebig;
      msum = eff_sub_ff ? (big_ff - small_ff) : (big_ff + small_ff);
      cnt_next = col_count_ff + 7'd1;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in = req_data.mode;
               idx_in  = req_data.index;
               coef_in = req_data.value;
               case (req_data.mode)
                  MODE_LOAD_TARGET: begin
                     t_we = 1'b1;
                  end
                  MODE_LOAD_MULT: begin
                     m_we = (req_data.index < 12'(MAX_COLUMNS));
                  end
                  MODE_READ: begin
                     t_re     = 1'b1;
                     state_in = ST_READ;
                  end
                  default: begin
                     first_in = (col_count_ff == 7'd0);
                     t_re     = (col_count_ff == 7'd0);
                     m_re     = 1'b1;
                     if (col_count_ff == 7'd0) begin
                        row_target_in = req_data.index;
                     end
                     state_in = ST_READ;
                  end
               endcase
            end
         end
         ST_READ: begin
            if (mode_ff == MODE_READ) begin
               if (out_free) begin
                  rsp_load = 1'b1;
                  rsp_in   = '{kind: KIND_READ, target_index: idx_ff, result_value: t_rdata};
                  state_in = ST_IDLE;
               end
            end else begin
               if (first_ff) begin
                  running_in = t_rdata;
               end
               mulv_in    = m_rdata;
               mul_cnt_in = 2'd0;
               macc_in    = 106'd0;
               state_in   = ST_MUL;
            end
         end
         ST_MUL: begin
            macc_in    = macc_ff + ({52'd0, pp} << pp_sh);
            mul_cnt_in = mul_cnt_ff + 2'd1;
            if (mul_cnt_ff == 2'd3) begin
               state_in = ST_MPACK;
            end
         end
         ST_MPACK: begin
            state_in = ST_ALIGN;
            if (is_nan(coef_ff)) begin
               prod_in = coef_ff | DBL_QUIET_BIT;
            end else if (is_nan(mulv_ff)) begin
               prod_in = mulv_ff | DBL_QUIET_BIT;
            end else if ((is_inf(coef_ff) && is_zero(mulv_ff))
                         || (is_zero(coef_ff) && is_inf(mulv_ff))) begin
               prod_in = DBL_DEFAULT_NAN;
            end else if (is_inf(coef_ff) || is_inf(mulv_ff)) begin
               prod_in = {coef_ff[63] ^ mulv_ff[63], 11'h7FF, 52'd0};
            end else if (is_zero(coef_ff) || is_zero(mulv_ff)) begin
               prod_in = {coef_ff[63] ^ mulv_ff[63], 63'd0};
            end else begin
               rp_sign_in = coef_ff[63] ^ mulv_ff[63];
               rp_m_in    = {22'd0, macc_ff};
               rp_e_in    = $signed(14'(ea)) + $signed(14'(eb)) - 14'sd2150;
               phase_in   = 1'b0;
               state_in   = ST_LZC;
            end
         end
         ST_LZC: begin
            lz_in    = clz128(rp_m_ff);
            state_in = ST_NORM;
         end
         ST_NORM: begin
            rp_m_in  = rp_m_ff << lz_ff;
            be_in    = rp_e_ff + 14'sd1150 - $signed(14'(lz_ff));
            state_in = ST_DEN;
         end
         ST_DEN: begin
            if (be_ff < 14'sd1) begin
               rp_m_in = (rp_m_ff >> sh)
                         | 128'(|(rp_m_ff & ~({128{1'b1}} << sh)));
            end
            state_in = ST_RND;
         end
         ST_RND: begin
            if (!phase_ff) begin
               prod_in  = res;
               state_in = ST_ALIGN;
            end else begin
               running_in = res;
               state_in   = ST_DONE;
            end
         end
         ST_ALIGN: begin
            state_in = ST_DONE;
            if (is_nan(xv)) begin
               running_in = xv | DBL_QUIET_BIT;
            end else if (is_nan(prod_ff)) begin
               running_in = prod_ff | DBL_QUIET_BIT;
            end else if (is_inf(xv) && is_inf(yv) && (xv[63] != yv[63])) begin
               running_in = DBL_DEFAULT_NAN;
            end else if (is_inf(xv)) begin
               running_in = xv;
            end else if (is_inf(yv)) begin
               running_in = yv;
            end else if (is_zero(xv) && is_zero(yv)) begin
               running_in = {xv[63] & yv[63], 63'd0};
            end else begin
               big_in = {2'b00, mbig, 73'd0};
               if (dexp <= 11'd73) begin
                  small_in = {2'b00, msml, 73'd0} >> dexp;
               end else begin
                  small_in = 128'(|msml);
               end
               eff_sub_in = xv[63] ^ yv[63];
               rp_sign_in = bigv[63];
               rp_e_in    = $signed(14'(bexp)) - 14'sd1148;
               state_in   = ST_ADD;
            end
         end
         ST_ADD: begin
            if (msum == 128'd0) begin
               running_in = 64'd0;
               state_in   = ST_DONE;
            end else begin
               rp_m_in  = msum;
               phase_in = 1'b1;
               state_in = ST_LZC;
            end
         end
         ST_DONE: begin
            if (11'(cnt_next) >= width11) begin
               if (out_free) begin
                  t_we         = 1'b1;
                  t_waddr      = taddr(row_target_ff);
                  t_wdata      = running_ff;
                  rsp_load     = 1'b1;
                  rsp_in       = '{kind: KIND_ROW, target_index: row_target_ff,
                                   result_value: running_ff};
                  col_count_in = 7'd0;
                  state_in     = ST_IDLE;
               end
            end else begin
               col_count_in = cnt_next;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         col_count_ff  <= 7'd0;
         row_target_ff <= 12'd0;
         running_ff    <= 64'd0;
         mul_cnt_ff    <= 2'd0;
         cfg_cols_ff   <= 7'd1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         col_count_ff  <= col_count_in;
         row_target_ff <= row_target_in;
         running_ff    <= running_in;
         mul_cnt_ff    <= mul_cnt_in;
         cfg_cols_ff   <= cfg_cols_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      mode_ff     <= mode_in;
      idx_ff      <= idx_in;
      coef_ff     <= coef_in;
      mulv_ff     <= mulv_in;
      first_ff    <= first_in;
      prod_ff     <= prod_in;
      phase_ff    <= phase_in;
      macc_ff     <= macc_in;
      rp_sign_ff  <= rp_sign_in;
      rp_m_ff     <= rp_m_in;
      rp_e_ff     <= rp_e_in;
      lz_ff       <= lz_in;
      be_ff       <= be_in;
      big_ff      <= big_in;
      small_ff    <= small_in;
      eff_sub_ff  <= eff_sub_in;
      rsp_data_ff <= rsp_in;
   end

   `GBU_ASSERT_IMP(a_no_overwrite, clock, reset, rsp_load, (!rsp_valid_ff || !rsp_stall))
   `GBU_ASSERT_IMP(a_count_range, clock, reset, 1'b1, (11'(col_count_ff) < 11'(MAX_COLUMNS)))
   `GBU_ASSERT_NXT(a_row_clears, clock, reset, (rsp_load && (rsp_in.kind == KIND_ROW)), (col_count_ff == 7'd0))
   `GBU_ASSERT_IMP(a_mul_cnt_idle, clock, reset, (state_ff != ST_MUL), (mul_cnt_ff == 2'd0))

endmodule
